[src/capped_cylinder_signed_distance_core_defines.svh]
// Assertion macros shared by the capped cylinder distance RTL.
`ifndef CAPPED_CYLINDER_SIGNED_DISTANCE_CORE_DEFINES_SVH
`define CAPPED_CYLINDER_SIGNED_DISTANCE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CCSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccsd assertion failed");

// Next-cycle implication, checked outside reset.
`define CCSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccsd assertion failed");

`endif

[src/ccsd_pkg.sv]
// Package with constants and types of the capped cylinder distance core.
`default_nettype none
package ccsd_pkg;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAP_X  = 8'd0,
    REG_CAP_Y  = 8'd1,
    REG_CAP_Z  = 8'd2,
    REG_AXIS_X = 8'd3,
    REG_AXIS_Y = 8'd4,
    REG_AXIS_Z = 8'd5,
    REG_RADIUS = 8'd6,
    REG_HEIGHT = 8'd7
  } ccsd_reg_t;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // Side data carried alongside a square root.
  typedef struct packed {
    logic               flag_a;
    logic               flag_b;
    logic signed [39:0] value;
  } ccsd_side_t;
endpackage
`default_nettype wire

[src/ccsd_point_if.sv]
// Channel interface for query point words.
`default_nettype none
interface ccsd_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface
`default_nettype wire

[src/ccsd_dist_if.sv]
// Channel interface for distance result words.
`default_nettype none
interface ccsd_dist_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] signed_dist;
  logic               saturated;
  modport source (output valid, signed_dist, saturated, input ready);
  modport sink (input valid, signed_dist, saturated, output ready);
endinterface
`default_nettype wire

[src/ccsd_cfg_if.sv]
// Configuration write channel interface.
`default_nettype none
interface ccsd_cfg_if;
  import ccsd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/ccsd_isqrt.sv]
// Pipelined 64-bit integer square root, one result bit per stage.
`default_nettype none
module ccsd_isqrt
  import ccsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [63:0] radicand,
  input  wire ccsd_side_t  in_side,
  output logic             out_valid,
  output logic [31:0]      root,
  output ccsd_side_t       out_side
);
  localparam int STAGES = 32;

  logic [63:0] rem_q  [1:STAGES];
  logic [63:0] acc_q  [1:STAGES];
  ccsd_side_t  side_q [1:STAGES];
  logic        vld_q  [1:STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] rem_in;
    logic [63:0] acc_in;
    ccsd_side_t  side_in;
    logic        vld_in;
    logic [63:0] trial;
    logic [63:0] rem_next;
    logic [63:0] acc_next;

    // The first stage takes the incoming word, the others the stage before.
    if (k == 0) begin : g_first
      assign rem_in  = radicand;
      assign acc_in  = '0;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_q[k];
      assign acc_in  = acc_q[k];
      assign side_in = side_q[k];
      assign vld_in  = vld_q[k];
    end

    // One restoring step: subtract the trial value when it fits.
    always_comb begin
      trial = acc_in + BIT;
      if (rem_in >= trial) begin
        rem_next = rem_in - trial;
        acc_next = (acc_in >> 1) + BIT;
      end else begin
        rem_next = rem_in;
        acc_next = acc_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_in;
      end
      if (en) begin
        rem_q[k+1]  <= rem_next;
        acc_q[k+1]  <= acc_next;
        side_q[k+1] <= side_in;
      end
    end
  end

  assign out_valid = vld_q[STAGES];
  assign root      = acc_q[STAGES][31:0];
  assign out_side  = side_q[STAGES];
endmodule
`default_nettype wire

[src/capped_cylinder_signed_distance_core.sv]
// Throughput: one word per cycle unless the output stalls.
// The square root units set the depth at one bit a stage.
// The whole pipeline advances together and holds while a result waits to be taken.
// Reset (rst, synchronous) empties the pipeline and loads cap 0, axis (0,0,1.0),
// radius 1.0 and height 1.0.
`default_nettype none
`include "capped_cylinder_signed_distance_core_defines.svh"
module capped_cylinder_signed_distance_core
  import ccsd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  ccsd_point_if.sink   point_in,
  ccsd_dist_if.source  dist_out,
  ccsd_cfg_if.sink     cfg
);
  localparam logic signed [55:0] HALF = 56'sd1 <<< (FRAC_BITS - 1);

  // Configuration registers.
  logic signed [31:0] cap_x, cap_y, cap_z;
  logic signed [17:0] axis_x, axis_y, axis_z;
  logic [30:0]        radius_len, height_len;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_x      <= '0;
      cap_y      <= '0;
      cap_z      <= '0;
      axis_x     <= '0;
      axis_y     <= '0;
      axis_z     <= 18'sd65536;
      radius_len <= 31'd65536;
      height_len <= 31'd65536;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CAP_X:  cap_x      <= cfg.data;
        REG_CAP_Y:  cap_y      <= cfg.data;
        REG_CAP_Z:  cap_z      <= cfg.data;
        REG_AXIS_X: axis_x     <= cfg.data[17:0];
        REG_AXIS_Y: axis_y     <= cfg.data[17:0];
        REG_AXIS_Z: axis_z     <= cfg.data[17:0];
        REG_RADIUS: radius_len <= cfg.data[30:0];
        REG_HEIGHT: height_len <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  // Pipeline enable: everything moves unless the output word is stalled.
  logic en;
  logic out_valid;
  assign en             = !out_valid || dist_out.ready;
  assign point_in.ready = en;

  logic vld1, vld2, vld3, vld4, vld5, vld6, vld7, vld8, vld9, vld10;
  logic signed [32:0] v1x, v1y, v1z, v2x, v2y, v2z, v3x, v3y, v3z, v4x, v4y, v4z;
  logic signed [50:0] pr2x, pr2y, pr2z;
  logic signed [37:0] ax3, ax4;
  logic signed [55:0] q4x, q4y, q4z;
  logic [31:0]        m5x, m5y, m5z;
  logic               far5, far6, far7;
  logic signed [39:0] plane5, plane6, plane7;
  logic [63:0]        sq6x, sq6y, sq6z;
  logic [63:0]        sum7;

  // Combinational values of stages 3, 5 and 7.
  logic signed [52:0] dsum;
  logic signed [55:0] qrx, qry, qrz;
  logic signed [40:0] px, py, pz;
  logic [40:0]        ax_mag, ay_mag, az_mag;
  logic signed [39:0] axial_w, hneg;
  logic [65:0]        sum_w;

  function automatic logic signed [52:0] v2x_ext(input logic signed [50:0] x);
    v2x_ext = 53'(x);
  endfunction

  always_comb begin
    dsum = 53'(v2x_ext(pr2x)) + 53'(v2x_ext(pr2y)) + 53'(v2x_ext(pr2z)) + 53'(HALF);
    qrx  = (q4x + HALF) >>> FRAC_BITS;
    qry  = (q4y + HALF) >>> FRAC_BITS;
    qrz  = (q4z + HALF) >>> FRAC_BITS;
    px   = 41'(v4x) - 41'(qrx);
    py   = 41'(v4y) - 41'(qry);
    pz   = 41'(v4z) - 41'(qrz);
    ax_mag = px[40] ? 41'(-px) : 41'(px);
    ay_mag = py[40] ? 41'(-py) : 41'(py);
    az_mag = pz[40] ? 41'(-pz) : 41'(pz);
    axial_w = 40'(ax4);
    hneg    = -$signed({9'd0, height_len}) - axial_w;
    sum_w   = {2'b00, sq6x} + {2'b00, sq6y} + {2'b00, sq6z};
  end

  // Stages 1 to 7: offset, dot product, projection, plane distance, squared radial length.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0; vld2 <= 1'b0; vld3 <= 1'b0; vld4 <= 1'b0;
      vld5 <= 1'b0; vld6 <= 1'b0; vld7 <= 1'b0;
    end else if (en) begin
      vld1 <= point_in.valid; vld2 <= vld1; vld3 <= vld2; vld4 <= vld3;
      vld5 <= vld4; vld6 <= vld5; vld7 <= vld6;
    end
    if (en) begin
      v1x <= 33'(point_in.point_x) - 33'(cap_x);
      v1y <= 33'(point_in.point_y) - 33'(cap_y);
      v1z <= 33'(point_in.point_z) - 33'(cap_z);
      pr2x <= v1x * axis_x;
      pr2y <= v1y * axis_y;
      pr2z <= v1z * axis_z;
      v2x <= v1x; v2y <= v1y; v2z <= v1z;
      ax3 <= 38'(dsum >>> FRAC_BITS);
      v3x <= v2x; v3y <= v2y; v3z <= v2z;
      q4x <= ax3 * axis_x;
      q4y <= ax3 * axis_y;
      q4z <= ax3 * axis_z;
      ax4 <= ax3;
      v4x <= v3x; v4y <= v3y; v4z <= v3z;
      m5x <= ax_mag[31:0];
      m5y <= ay_mag[31:0];
      m5z <= az_mag[31:0];
      far5 <= (ax_mag[40:32] != '0) || (ay_mag[40:32] != '0) || (az_mag[40:32] != '0);
      plane5 <= (axial_w > hneg) ? axial_w : hneg;
      sq6x <= 64'(m5x) * 64'(m5x);
      sq6y <= 64'(m5y) * 64'(m5y);
      sq6z <= 64'(m5z) * 64'(m5z);
      far6 <= far5;
      plane6 <= plane5;
      sum7 <= sum_w[63:0];
      far7 <= far6 || (sum_w[65:64] != 2'b00);
      plane7 <= plane6;
    end
  end

  // First square root: length of the perpendicular part.
  ccsd_side_t side_in1, side_out1;
  logic       sq1_valid;
  logic [31:0] root1;
  assign side_in1 = '{flag_a: far7, flag_b: 1'b0, value: plane7};

  ccsd_isqrt u_isqrt_radial (
    .clk(clk), .rst(rst), .en(en), .in_valid(vld7), .radicand(sum7),
    .in_side(side_in1), .out_valid(sq1_valid), .root(root1), .out_side(side_out1)
  );

  // Stage 8: radial distance and choice of result form.
  logic signed [39:0] cyl_w, plane_w, alt_w;
  logic               both_pos, in_range;
  always_comb begin
    cyl_w    = $signed({8'd0, root1}) - $signed({9'd0, radius_len});
    plane_w  = side_out1.value;
    both_pos = (cyl_w > 40'sd0) && (plane_w > 40'sd0);
    in_range = (cyl_w <= 40'(S32_MAX)) && (plane_w <= 40'(S32_MAX));
    alt_w    = (cyl_w > plane_w) ? cyl_w : plane_w;
  end

  logic        use_root8, force8, use_root9, force9, use_root10, force10;
  logic signed [39:0] alt8, alt9, alt10;
  logic [30:0] cyl8, pl8;
  logic [61:0] cs9, ps9;
  logic [63:0] sum10;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld8 <= 1'b0; vld9 <= 1'b0; vld10 <= 1'b0;
    end else if (en) begin
      vld8 <= sq1_valid; vld9 <= vld8; vld10 <= vld9;
    end
    if (en) begin
      use_root8 <= !side_out1.flag_a && both_pos && in_range;
      force8    <= side_out1.flag_a || (both_pos && !in_range);
      alt8      <= alt_w;
      cyl8      <= cyl_w[30:0];
      pl8       <= plane_w[30:0];
      cs9       <= 62'(cyl8) * 62'(cyl8);
      ps9       <= 62'(pl8) * 62'(pl8);
      use_root9 <= use_root8; force9 <= force8; alt9 <= alt8;
      sum10     <= {1'b0, 63'(cs9) + 63'(ps9)};
      use_root10 <= use_root9; force10 <= force9; alt10 <= alt9;
    end
  end

  // Second square root: distance past the rim.
  ccsd_side_t side_in2, side_out2;
  logic       sq2_valid;
  logic [31:0] root2;
  assign side_in2 = '{flag_a: use_root10, flag_b: force10, value: alt10};

  ccsd_isqrt u_isqrt_rim (
    .clk(clk), .rst(rst), .en(en), .in_valid(vld10), .radicand(sum10),
    .in_side(side_in2), .out_valid(sq2_valid), .root(root2), .out_side(side_out2)
  );

  // Output stage: pick and saturate the result word.
  logic signed [31:0] dist_next;
  logic               sat_next;
  always_comb begin
    if (side_out2.flag_b) begin
      dist_next = S32_MAX; sat_next = 1'b1;
    end else if (side_out2.flag_a) begin
      if (root2[31]) begin
        dist_next = S32_MAX; sat_next = 1'b1;
      end else begin
        dist_next = root2; sat_next = 1'b0;
      end
    end else if (side_out2.value > 40'(S32_MAX)) begin
      dist_next = S32_MAX; sat_next = 1'b1;
    end else if (side_out2.value < 40'(S32_MIN)) begin
      dist_next = S32_MIN; sat_next = 1'b1;
    end else begin
      dist_next = side_out2.value[31:0]; sat_next = 1'b0;
    end
  end

  logic signed [31:0] dist_q;
  logic               sat_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sq2_valid;
    end
    if (en) begin
      dist_q <= dist_next;
      sat_q  <= sat_next;
    end
  end

  assign dist_out.valid       = out_valid;
  assign dist_out.signed_dist = dist_q;
  assign dist_out.saturated   = sat_q;

  // A clipped word always carries one of the two range limits.
  `CCSD_ASSERT_NOW(a_sat_limit, out_valid && sat_q, (dist_q == S32_MAX) || (dist_q == S32_MIN))
  // A stalled output word is still there in the next cycle.
  `CCSD_ASSERT_NEXT(a_stall_hold, out_valid && !dist_out.ready, out_valid && $stable(dist_q))
  // A word in the first stage is kept while the pipeline is held.
  `CCSD_ASSERT_NEXT(a_stage_hold, vld1 && !en, vld1)
endmodule
`default_nettype wire
